@@ hdl/tam_pkg.sv @@
// ---------------------------------------------------------------------------
// tam_pkg
// Shared types and constants of the three-address machine core.
// ---------------------------------------------------------------------------
package tam_pkg;

  localparam int DATA_W = 32;
  localparam int OPC_W  = 8;

  localparam logic [1:0] REQ_LOAD_CMD = 2'd0;
  localparam logic [1:0] REQ_LOAD_VAL = 2'd1;
  localparam logic [1:0] REQ_EXEC     = 2'd2;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_OPCODE = 2'd1;
  localparam logic [1:0] ERR_DIVZ   = 2'd2;

  localparam logic [7:0] OP_ASSIGN = 8'd0;
  localparam logic [7:0] OP_ADD    = 8'd1;
  localparam logic [7:0] OP_SUB    = 8'd2;
  localparam logic [7:0] OP_MUL    = 8'd3;
  localparam logic [7:0] OP_DIV    = 8'd4;
  localparam logic [7:0] OP_IN     = 8'd6;
  localparam logic [7:0] OP_OUT    = 8'd7;
  localparam logic [7:0] OP_UMUL   = 8'd19;
  localparam logic [7:0] OP_UDIV   = 8'd20;
  localparam logic [7:0] OP_UIN    = 8'd22;
  localparam logic [7:0] OP_UOUT   = 8'd23;
  localparam logic [7:0] OP_GOTO   = 8'd128;
  localparam logic [7:0] OP_EQ     = 8'd129;
  localparam logic [7:0] OP_NE     = 8'd130;
  localparam logic [7:0] OP_LT     = 8'd131;
  localparam logic [7:0] OP_GE     = 8'd132;
  localparam logic [7:0] OP_GT     = 8'd133;
  localparam logic [7:0] OP_LE     = 8'd134;
  localparam logic [7:0] OP_ULT    = 8'd147;
  localparam logic [7:0] OP_ULE    = 8'd148;
  localparam logic [7:0] OP_UGT    = 8'd149;
  localparam logic [7:0] OP_UGE    = 8'd150;
  localparam logic [7:0] OP_STOP   = 8'd153;

  typedef struct packed {
    logic                start;
    logic                signed_op;
    logic [DATA_W-1:0]   dividend;
    logic [DATA_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DATA_W-1:0]   quotient;
    logic [DATA_W-1:0]   remainder;
  } div_rsp_t;

endpackage

@@ hdl/three_address_machine_core.sv @@
// ---------------------------------------------------------------------------
// three_address_machine_core
// Three-address machine: one instruction per execute request.
// ---------------------------------------------------------------------------
// Requests enter on in_valid/in_ready; each gives one result on
// res_valid/res_ready. A load request writes one cell and moves the pc to
// start_address; an execute request runs the instruction at the pc.
// start_address is written on the cfg channel while the core is idle.
// A load writes its cell from the command state. An execute reads the command,
// A1 and A2 in turn through the single memory read port, then executes; divide
// also waits for the bit-serial divider and for the second write-back.
// One request at a time; the next one is taken the cycle after a result
// is registered.
// The result sits in an output register; the next request is taken while it
// waits, but its own result waits until that register is free.
// Reset clears pc, halt flag, start_address and all handshake state; the
// memory holds garbage until written and must not be read before.
// ---------------------------------------------------------------------------
module three_address_machine_core #(
  parameter int ADDR_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] start_address,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] cell_address,
  input  logic [7:0]  load_opcode,
  input  logic [15:0] operand_one,
  input  logic [15:0] operand_two,
  input  logic [15:0] operand_three,
  input  logic signed [31:0] data_value,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [15:0] next_pc,
  output logic        out_valid,
  output logic signed [31:0] out_value,
  output logic        out_is_unsigned,
  output logic        input_used,
  output logic        halted,
  output logic [1:0]  error_code
);
  import tam_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int WW = WORD_BITS;
  localparam int CELL_BITS = 1 + OPC_W + 3 * AW;
  localparam int CW = (CELL_BITS > WW + 1) ? CELL_BITS : WW + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CMD   = 8'b00000010,
    S_OPA   = 8'b00000100,
    S_OPB   = 8'b00001000,
    S_EXEC  = 8'b00010000,
    S_DIV   = 8'b00100000,
    S_WB2   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state;

  logic [AW-1:0] start_reg;
  logic [AW-1:0] pc;
  logic          halt;

  logic [1:0]    rq_type;
  logic [AW-1:0] rq_addr;
  logic [7:0]    rq_opc;
  logic [AW-1:0] rq_a1;
  logic [AW-1:0] rq_a2;
  logic [AW-1:0] rq_a3;
  logic [WW-1:0] rq_data;

  logic [7:0]    c_opc;
  logic [AW-1:0] c_a1;
  logic [AW-1:0] c_a2;
  logic [AW-1:0] c_a3;
  logic [WW-1:0] x;
  logic [WW-1:0] y;
  logic [WW-1:0] rem_hold;

  logic          r_ovalid;
  logic [WW-1:0] r_oval;
  logic          r_ouns;
  logic          r_iused;
  logic [1:0]    r_err;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [CW-1:0] mem_rdata;

  div_req_t dreq;
  div_rsp_t drsp;

  tam_mem #(.ADDR_BITS(AW), .CELL_BITS(CW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tam_div #(.WORD_BITS(WW)) u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // cell layout: [CW-1] command flag; command: opcode, a1, a2, a3; value: low bits
  function automatic logic [CW-1:0] pack_val(input logic [WW-1:0] v);
    pack_val = {1'b0, (CW-1)'(v)};
  endfunction

  logic          rd_cmd;
  logic [7:0]    rd_opc;
  logic [AW-1:0] rd_a1;
  logic [AW-1:0] rd_a2;
  logic [AW-1:0] rd_a3;
  logic [WW-1:0] rd_val;

  assign rd_cmd = mem_rdata[CW-1];
  assign rd_opc = mem_rdata[3*AW +: 8];
  assign rd_a1  = mem_rdata[2*AW +: AW];
  assign rd_a2  = mem_rdata[AW +: AW];
  assign rd_a3  = mem_rdata[0 +: AW];
  assign rd_val = rd_cmd ? WW'(rd_opc) : mem_rdata[WW-1:0];

  logic [WW-1:0] prod;
  logic          s_lt;
  logic          u_lt;
  logic          eq;
  logic [AW-1:0] pc_inc;

  assign prod   = WW'(x * y);
  assign eq     = (x == y);
  assign u_lt   = (x < y);
  assign s_lt   = ($signed(x) < $signed(y));
  assign pc_inc = pc + 1'b1;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    mem_raddr = pc;
    case (state)
      S_IDLE: mem_raddr = pc;
      S_CMD:  mem_raddr = rd_a1;
      S_OPA:  mem_raddr = c_a2;
      default: mem_raddr = pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start_reg <= '0;
      pc        <= '0;
      halt      <= 1'b0;
      res_valid <= 1'b0;
      mem_we    <= 1'b0;
      dreq      <= '0;
    end else begin
      mem_we     <= 1'b0;
      dreq.start <= 1'b0;
      if (res_valid && res_ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            start_reg <= start_address[AW-1:0];
          end
          if (in_valid) begin
            rq_type  <= req_type;
            rq_addr  <= cell_address[AW-1:0];
            rq_opc   <= load_opcode;
            rq_a1    <= operand_one[AW-1:0];
            rq_a2    <= operand_two[AW-1:0];
            rq_a3    <= operand_three[AW-1:0];
            rq_data  <= WW'(data_value);
            r_ovalid <= 1'b0;
            r_oval   <= '0;
            r_ouns   <= 1'b0;
            r_iused  <= 1'b0;
            r_err    <= ERR_NONE;
            state    <= S_CMD;
          end
        end
        S_CMD: begin
          c_opc <= rd_opc;
          c_a1  <= rd_a1;
          c_a2  <= rd_a2;
          c_a3  <= rd_a3;
          state <= S_OPA;
          if (rq_type == REQ_LOAD_CMD) begin
            mem_we    <= 1'b1;
            mem_waddr <= rq_addr;
            mem_wdata <= CW'({1'b1, rq_opc, rq_a1, rq_a2, rq_a3});
            pc        <= start_reg;
            halt      <= 1'b0;
            state     <= S_DONE;
          end else if (rq_type == REQ_LOAD_VAL) begin
            mem_we    <= 1'b1;
            mem_waddr <= rq_addr;
            mem_wdata <= pack_val(rq_data);
            pc        <= start_reg;
            halt      <= 1'b0;
            state     <= S_DONE;
          end else if (rq_type != REQ_EXEC || halt) begin
            state <= S_DONE;
          end else if (!rd_cmd) begin
            halt  <= 1'b1;
            r_err <= ERR_OPCODE;
            state <= S_DONE;
          end
        end
        S_OPA: begin
          x     <= rd_val;
          state <= S_OPB;
        end
        S_OPB: begin
          y     <= rd_val;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_DONE;
          case (c_opc)
            OP_ASSIGN, OP_ADD, OP_SUB, OP_MUL, OP_UMUL: begin
              mem_we    <= 1'b1;
              mem_waddr <= c_a3;
              case (c_opc)
                OP_ASSIGN: mem_wdata <= pack_val(x);
                OP_ADD:    mem_wdata <= pack_val(x + y);
                OP_SUB:    mem_wdata <= pack_val(x - y);
                default:   mem_wdata <= pack_val(prod);
              endcase
              pc <= pc_inc;
            end
            OP_DIV, OP_UDIV: begin
              if (y == '0) begin
                halt  <= 1'b1;
                r_err <= ERR_DIVZ;
              end else begin
                dreq.start     <= 1'b1;
                dreq.signed_op <= (c_opc == OP_DIV);
                dreq.dividend  <= DATA_W'(x);
                dreq.divisor   <= DATA_W'(y);
                state          <= S_DIV;
              end
            end
            OP_IN, OP_UIN: begin
              mem_we    <= 1'b1;
              mem_waddr <= c_a1;
              mem_wdata <= pack_val(rq_data);
              r_iused   <= 1'b1;
              pc        <= pc_inc;
            end
            OP_OUT: begin
              r_ovalid <= 1'b1;
              r_oval   <= x;
              pc       <= pc_inc;
            end
            OP_UOUT: begin
              r_ovalid <= 1'b1;
              r_oval   <= x;
              r_ouns   <= 1'b1;
              pc       <= pc_inc;
            end
            OP_GOTO: pc <= c_a3;
            OP_EQ:   pc <= eq ? c_a3 : pc_inc;
            OP_NE:   pc <= !eq ? c_a3 : pc_inc;
            OP_LT:   pc <= s_lt ? c_a3 : pc_inc;
            OP_GE:   pc <= !s_lt ? c_a3 : pc_inc;
            OP_GT:   pc <= (!s_lt && !eq) ? c_a3 : pc_inc;
            OP_LE:   pc <= (s_lt || eq) ? c_a3 : pc_inc;
            OP_ULT:  pc <= u_lt ? c_a3 : pc_inc;
            OP_ULE:  pc <= (u_lt || eq) ? c_a3 : pc_inc;
            OP_UGT:  pc <= (!u_lt && !eq) ? c_a3 : pc_inc;
            OP_UGE:  pc <= !u_lt ? c_a3 : pc_inc;
            OP_STOP: halt <= 1'b1;
            default: begin
              halt  <= 1'b1;
              r_err <= ERR_OPCODE;
            end
          endcase
        end
        S_DIV: begin
          if (drsp.done) begin
            mem_we    <= 1'b1;
            mem_waddr <= c_a3;
            mem_wdata <= pack_val(drsp.quotient[WW-1:0]);
            rem_hold  <= drsp.remainder[WW-1:0];
            state     <= S_WB2;
          end
        end
        S_WB2: begin
          mem_we    <= 1'b1;
          mem_waddr <= c_a3 + 1'b1;
          mem_wdata <= pack_val(rem_hold);
          pc        <= pc_inc;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid       <= 1'b1;
            next_pc         <= 16'(pc);
            out_valid       <= r_ovalid;
            out_value       <= r_ouns ? 32'(r_oval) : 32'($signed(r_oval));
            out_is_unsigned <= r_ouns;
            input_used      <= r_iused;
            halted          <= halt;
            error_code      <= r_err;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/tam_div.sv @@
// ---------------------------------------------------------------------------
// tam_div
// Iterative divider, one quotient bit per cycle, signed or unsigned.
// ---------------------------------------------------------------------------
module tam_div #(
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  tam_pkg::div_req_t req,
  output tam_pkg::div_rsp_t rsp
);
  import tam_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] dvs;
  logic                 neg_q;
  logic                 neg_r;
  logic                 done;

  logic [WORD_BITS-1:0] a_in;
  logic [WORD_BITS-1:0] b_in;
  logic                 a_neg;
  logic                 b_neg;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   shifted;

  assign a_in  = req.dividend[WORD_BITS-1:0];
  assign b_in  = req.divisor[WORD_BITS-1:0];
  assign a_neg = req.signed_op & a_in[WORD_BITS-1];
  assign b_neg = req.signed_op & b_in[WORD_BITS-1];
  assign shifted = {rem, quo[WORD_BITS-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(WORD_BITS);
        quo   <= a_neg ? -a_in : a_in;
        dvs   <= b_neg ? -b_in : b_in;
        rem   <= '0;
        neg_q <= a_neg ^ b_neg;
        neg_r <= a_neg;
      end else if (busy) begin
        if (!trial[WORD_BITS]) begin
          rem <= trial[WORD_BITS-1:0];
          quo <= {quo[WORD_BITS-2:0], 1'b1};
        end else begin
          rem <= shifted[WORD_BITS-1:0];
          quo <= {quo[WORD_BITS-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp           = '0;
    rsp.done      = done;
    rsp.quotient  = DATA_W'(neg_q ? -quo : quo);
    rsp.remainder = DATA_W'(neg_r ? -rem : rem);
  end

endmodule

@@ hdl/tam_mem.sv @@
// ---------------------------------------------------------------------------
// tam_mem
// Main cell memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tam_mem #(
  parameter int ADDR_BITS = 16,
  parameter int CELL_BITS = 57
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [CELL_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [CELL_BITS-1:0] rdata
);
  logic [CELL_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/tam_checker.sv @@
// ---------------------------------------------------------------------------
// tam_checker
// Port-level checks of the three-address machine core.
// ---------------------------------------------------------------------------
module tam_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        out_valid,
  input logic        out_is_unsigned,
  input logic        input_used,
  input logic        halted,
  input logic [1:0]  error_code,
  input logic [15:0] next_pc
);
  import tam_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(next_pc))
    else $error("result dropped while stalled");

  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    res_valid && error_code != ERR_NONE |-> halted)
    else $error("error without halt");

  a_uns_out: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_is_unsigned |-> out_valid && !input_used)
    else $error("unsigned flag without output");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(out_valid && input_used))
    else $error("output and input in one result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind three_address_machine_core tam_checker u_tam_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .res_valid       (res_valid),
  .res_ready       (res_ready),
  .out_valid       (out_valid),
  .out_is_unsigned (out_is_unsigned),
  .input_used      (input_used),
  .halted          (halted),
  .error_code      (error_code),
  .next_pc         (next_pc)
);
